// ----- rtl/ilst_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none

package ilst_pkg;

   localparam int FUNC_W           = 3;
   localparam int POSITION_W       = 7;
   localparam int DATA_W           = 32;
   localparam int COUNT_OUT_W      = 7;
   localparam int DEFAULT_CAPACITY = 64;

   typedef enum logic [FUNC_W-1:0] {
      FN_READ       = 3'd0,
      FN_INSERT_AT  = 3'd1,
      FN_PUSH_FRONT = 3'd2,
      FN_PUSH_BACK  = 3'd3,
      FN_REMOVE_AT  = 3'd4,
      FN_POP_FRONT  = 3'd5,
      FN_POP_BACK   = 3'd6
   } func_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic latch;          // capture the request fields
      logic cursor_init;    // load the shift cursor
      logic cursor_step;    // advance the shift cursor by one entry
      logic mem_rd;         // issue a memory read
      logic rd_sel_target;  // read at the target position, else at the shift source
      logic mem_wr;         // issue a memory write
      logic wr_sel_place;   // write the new value at the target, else the shifted entry
      logic cnt_inc;
      logic cnt_dec;
      logic respond;        // load the result registers
      logic resp_ok;
      logic resp_read;      // the result carries the value read
   } cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic legal;
      logic is_read;
      logic is_insert;
      logic shift_done;
   } status_type;

endpackage

`default_nettype wire

// ----- rtl/ilst_datapath.sv -----
`timescale 1ns / 1ps
`default_nettype none

module ilst_datapath
   import ilst_pkg::*;
#(
   parameter int CAPACITY = DEFAULT_CAPACITY
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire cmd_type                       cmd,
   output status_type                         status,
   input  wire logic [FUNC_W-1:0]             req_func,
   input  wire logic [POSITION_W-1:0]         req_position,
   input  wire logic signed [DATA_W-1:0]      req_item_value,
   output logic                               rsp_strobe,
   output logic                               rsp_ok,
   output logic signed [DATA_W-1:0]           rsp_read_value,
   output logic [COUNT_OUT_W-1:0]             rsp_entry_count,
   output logic                               rsp_is_empty
);

   localparam int CNT_W  = $clog2(CAPACITY + 1);
   localparam int ADDR_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
   localparam int CMP_W  = (CNT_W > POSITION_W) ? CNT_W : POSITION_W;
   localparam logic [CMP_W-1:0] CAP_CMP = CMP_W'(CAPACITY);

   func_type                  func_ff;
   logic [POSITION_W-1:0]     pos_ff;
   logic [DATA_W-1:0]         value_ff;
   logic [CNT_W-1:0]          count_ff;
   logic [CNT_W-1:0]          count_in;
   logic [CNT_W-1:0]          cursor_ff;
   logic [CNT_W-1:0]          cursor_in;
   logic [DATA_W-1:0]         mem_rdata_ff;
   logic [DATA_W-1:0]         mem [CAPACITY];

   logic                      rsp_strobe_ff;
   logic                      rsp_ok_ff;
   logic [DATA_W-1:0]         rsp_read_value_ff;
   logic [COUNT_OUT_W-1:0]    rsp_entry_count_ff;
   logic                      rsp_is_empty_ff;

   logic [CMP_W-1:0]          cnt_cmp;
   logic [CMP_W-1:0]          pos_cmp;
   logic [CMP_W-1:0]          epos_cmp;
   logic [CMP_W-1:0]          cnt_in_cmp;
   logic [CNT_W-1:0]          epos;
   logic [CNT_W-1:0]          src;
   logic [CNT_W:0]            cursor_next_wide;
   logic                      full;
   logic                      empty;
   logic                      legal;
   logic                      is_insert;
   logic [ADDR_W-1:0]         rd_idx;
   logic [ADDR_W-1:0]         wr_idx;
   logic [DATA_W-1:0]         wr_data;

   assign cnt_cmp = CMP_W'(count_ff);
   assign pos_cmp = CMP_W'(pos_ff);
   assign full    = (cnt_cmp == CAP_CMP);
   assign empty   = (count_ff == '0);

   // Front operations work at position zero, back operations at the tail.
   always_comb begin
      case (func_ff)
         FN_PUSH_FRONT, FN_POP_FRONT: epos_cmp = '0;
         FN_PUSH_BACK:                epos_cmp = cnt_cmp;
         FN_POP_BACK:                 epos_cmp = cnt_cmp - CMP_W'(1);
         default:                     epos_cmp = pos_cmp;
      endcase
   end

   assign epos = epos_cmp[CNT_W-1:0];

   always_comb begin
      case (func_ff)
         FN_READ:                    legal = (pos_cmp < cnt_cmp);
         FN_INSERT_AT:               legal = !full && (pos_cmp <= cnt_cmp);
         FN_PUSH_FRONT, FN_PUSH_BACK: legal = !full;
         FN_REMOVE_AT:               legal = (pos_cmp < cnt_cmp);
         FN_POP_FRONT, FN_POP_BACK:  legal = !empty;
         default:                    legal = 1'b0;
      endcase
   end

   assign is_insert = func_ff inside {FN_INSERT_AT, FN_PUSH_FRONT, FN_PUSH_BACK};

   // An insert walks the cursor down from the tail, a remove walks it up from the target.
   assign src              = is_insert ? (cursor_ff - CNT_W'(1)) : (cursor_ff + CNT_W'(1));
   assign cursor_next_wide = (CNT_W + 1)'(cursor_ff) + (CNT_W + 1)'(1);

   assign status.legal      = legal;
   assign status.is_read    = (func_ff == FN_READ);
   assign status.is_insert  = is_insert;
   assign status.shift_done = is_insert ? (cursor_ff == epos)
                                        : (cursor_next_wide >= (CNT_W + 1)'(count_ff));

   always_comb begin
      cursor_in = cursor_ff;
      if (cmd.cursor_init) begin
         cursor_in = is_insert ? count_ff : epos;
      end else if (cmd.cursor_step) begin
         cursor_in = src;
      end
   end

   always_comb begin
      count_in = count_ff;
      if (cmd.cnt_inc) begin
         count_in = count_ff + CNT_W'(1);
      end else if (cmd.cnt_dec) begin
         count_in = count_ff - CNT_W'(1);
      end
   end

   assign cnt_in_cmp = CMP_W'(count_in);
   assign rd_idx     = cmd.rd_sel_target ? epos[ADDR_W-1:0] : src[ADDR_W-1:0];
   assign wr_idx     = cmd.wr_sel_place ? epos[ADDR_W-1:0] : cursor_ff[ADDR_W-1:0];
   assign wr_data    = cmd.wr_sel_place ? value_ff : mem_rdata_ff;

   always_ff @(posedge clock) begin
      if (cmd.mem_wr) begin
         mem[wr_idx] <= wr_data;
      end
      if (cmd.mem_rd) begin
         mem_rdata_ff <= mem[rd_idx];
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.latch) begin
         func_ff  <= func_type'(req_func);
         pos_ff   <= req_position;
         value_ff <= req_item_value;
      end
      cursor_ff <= cursor_in;
      if (cmd.respond) begin
         rsp_ok_ff          <= cmd.resp_ok;
         rsp_read_value_ff  <= cmd.resp_read ? mem_rdata_ff : '0;
         rsp_entry_count_ff <= cnt_in_cmp[COUNT_OUT_W-1:0];
         rsp_is_empty_ff    <= (count_in == '0);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff      <= '0;
         rsp_strobe_ff <= 1'b0;
      end else begin
         count_ff      <= count_in;
         rsp_strobe_ff <= cmd.respond;
      end
   end

   assign rsp_strobe      = rsp_strobe_ff;
   assign rsp_ok          = rsp_ok_ff;
   assign rsp_read_value  = rsp_read_value_ff;
   assign rsp_entry_count = rsp_entry_count_ff;
   assign rsp_is_empty    = rsp_is_empty_ff;

endmodule

`default_nettype wire

// ----- rtl/ilst_controller.sv -----
`timescale 1ns / 1ps
`default_nettype none

module ilst_controller
   import ilst_pkg::*;
(
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       start,
   output logic            busy,
   input  wire status_type status,
   output cmd_type         cmd
);

   typedef enum logic [4:0] {
      ST_IDLE      = 5'b00001,
      ST_DECIDE    = 5'b00010,
      ST_READ_WAIT = 5'b00100,
      ST_SH_RD     = 5'b01000,
      ST_SH_WR     = 5'b10000
   } state_type;

   state_type state_ff;
   state_type state_in;

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      case (state_ff)
         ST_IDLE: begin
            if (start) begin
               cmd.latch = 1'b1;
               state_in  = ST_DECIDE;
            end
         end
         ST_DECIDE: begin
            if (!status.legal) begin
               cmd.respond = 1'b1;
               state_in    = ST_IDLE;
            end else if (status.is_read) begin
               cmd.mem_rd        = 1'b1;
               cmd.rd_sel_target = 1'b1;
               state_in          = ST_READ_WAIT;
            end else begin
               cmd.cursor_init = 1'b1;
               state_in        = ST_SH_RD;
            end
         end
         ST_READ_WAIT: begin
            cmd.respond   = 1'b1;
            cmd.resp_ok   = 1'b1;
            cmd.resp_read = 1'b1;
            state_in      = ST_IDLE;
         end
         ST_SH_RD: begin
            if (status.shift_done) begin
               // The gap is open (or closed); finish the operation.
               if (status.is_insert) begin
                  cmd.mem_wr       = 1'b1;
                  cmd.wr_sel_place = 1'b1;
                  cmd.cnt_inc      = 1'b1;
               end else begin
                  cmd.cnt_dec = 1'b1;
               end
               cmd.respond = 1'b1;
               cmd.resp_ok = 1'b1;
               state_in    = ST_IDLE;
            end else begin
               cmd.mem_rd = 1'b1;
               state_in   = ST_SH_WR;
            end
         end
         ST_SH_WR: begin
            cmd.mem_wr      = 1'b1;
            cmd.cursor_step = 1'b1;
            state_in        = ST_SH_RD;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   assign busy = (state_ff != ST_IDLE);

endmodule

`default_nettype wire

// ----- rtl/indexed_ordered_list_store.sv -----
// A failed request responds from the decide state, a read from the read-wait state, and an
// insert or remove from the shift-read state after one read and write pair per moved entry.
// A new request can be accepted in the cycle the result strobe is shown; the entry memory
// moves one entry per read and write pair. Synchronous active-high reset empties the list
// and drops busy; entry contents are not cleared. Results are shown for one cycle and
// cannot be stalled.
`timescale 1ns / 1ps
`default_nettype none

module indexed_ordered_list_store
   import ilst_pkg::*;
#(
   parameter int CAPACITY = DEFAULT_CAPACITY
) (
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire logic                      start,
   output logic                           busy,
   input  wire logic [FUNC_W-1:0]         req_func,
   input  wire logic [POSITION_W-1:0]     req_position,
   input  wire logic signed [DATA_W-1:0]  req_item_value,
   output logic                           rsp_strobe,
   output logic                           rsp_ok,
   output logic signed [DATA_W-1:0]       rsp_read_value,
   output logic [COUNT_OUT_W-1:0]         rsp_entry_count,
   output logic                           rsp_is_empty
);

   cmd_type    cmd;
   status_type status;

   ilst_controller u_controller (
      .clock  (clock),
      .reset  (reset),
      .start  (start),
      .busy   (busy),
      .status (status),
      .cmd    (cmd)
   );

   ilst_datapath #(
      .CAPACITY (CAPACITY)
   ) u_datapath (
      .clock           (clock),
      .reset           (reset),
      .cmd             (cmd),
      .status          (status),
      .req_func        (req_func),
      .req_position    (req_position),
      .req_item_value  (req_item_value),
      .rsp_strobe      (rsp_strobe),
      .rsp_ok          (rsp_ok),
      .rsp_read_value  (rsp_read_value),
      .rsp_entry_count (rsp_entry_count),
      .rsp_is_empty    (rsp_is_empty)
   );

endmodule

`default_nettype wire

// ----- rtl/ilst_checker.sv -----
`timescale 1ns / 1ps
`default_nettype none

module ilst_checker
   import ilst_pkg::*;
(
   input wire logic                      clock,
   input wire logic                      reset,
   input wire logic                      start,
   input wire logic                      busy,
   input wire logic                      rsp_strobe,
   input wire logic                      rsp_ok,
   input wire logic signed [DATA_W-1:0]  rsp_read_value,
   input wire logic [COUNT_OUT_W-1:0]    rsp_entry_count,
   input wire logic                      rsp_is_empty
);

   // The empty flag must agree with the reported count.
   a_empty_matches_count: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> (rsp_is_empty == (rsp_entry_count == '0)))
      else $error("empty flag disagrees with entry count");

   // A failed request never carries read data.
   a_fail_reads_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && !rsp_ok) |-> (rsp_read_value == '0))
      else $error("failed request returned nonzero read data");

   // An accepted beat makes the block busy in the next cycle.
   a_accept_sets_busy: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> busy)
      else $error("block not busy after accepting a request");

   // A result is only shown once the block has finished with its request.
   a_result_when_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> !busy)
      else $error("result shown while still busy");

   // Results never come in adjacent cycles: each needs its own request.
   a_single_result: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |=> !rsp_strobe)
      else $error("result strobe held for two cycles");

endmodule

bind indexed_ordered_list_store ilst_checker u_ilst_checker (
   .clock           (clock),
   .reset           (reset),
   .start           (start),
   .busy            (busy),
   .rsp_strobe      (rsp_strobe),
   .rsp_ok          (rsp_ok),
   .rsp_read_value  (rsp_read_value),
   .rsp_entry_count (rsp_entry_count),
   .rsp_is_empty    (rsp_is_empty)
);

`default_nettype wire
